/* sv/qpd_pkg.sv */
package qpd_pkg;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_EQ    = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  typedef enum logic {
    JOB_BYTE = 1'b0,
    JOB_NL   = 1'b1
  } job_kind_t;

  // one unit of work for the back end: a decoded byte or a newline
  typedef struct packed {
    job_kind_t  kind;
    logic       crlf;
    logic [7:0] data;
    logic       bad;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_wr_t;

  typedef struct packed {
    logic full;
  } job_wr_st_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_rd_t;

  // 0..15, or bit 4 set when not a hex digit; lower case folds to upper
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] u;
    logic [4:0] r;
    u = b;
    if (b >= 8'h61 && b <= 8'h7A) u = b - 8'h20;
    if (u >= 8'h30 && u <= 8'h39) r = {1'b0, u[3:0]};
    else if (u >= 8'h41 && u <= 8'h46) r = 5'(u - 8'h41 + 8'd10);
    else r = 5'h10;
    return r;
  endfunction

endpackage

/* sv/quoted_printable_decoder_top.sv */
// A result is registered in the job queue and then in the output register.
// Throughput: one input beat per cycle while the job queue is not full; output drains
// one beat per cycle while out_pop is high; a CRLF newline is two beats. A four-entry
// job queue absorbs bursts between the input classifier and the output stage.
// Reset (rst_n low, synchronous): clears line/escape state, queue and output;
// newline mode returns to LF.
module quoted_printable_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_bad_hex,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_newline_crlf
);
  import qpd_pkg::*;

  job_wr_t    jq_wr;
  job_wr_st_t jq_st;
  job_rd_t    jq_rd;
  logic       jq_pop;

  qpd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_newline_crlf (cfg_newline_crlf),
    .jq_wr            (jq_wr),
    .jq_st            (jq_st)
  );

  qpd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (jq_wr),
    .wr_st  (jq_st),
    .rd     (jq_rd),
    .rd_pop (jq_pop)
  );

  qpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jq_rd           (jq_rd),
    .jq_pop          (jq_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_bad_hex     (out_bad_hex),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* sv/qpd_front.sv */
module qpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_stream,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_newline_crlf,
  output qpd_pkg::job_wr_t  jq_wr,
  input  qpd_pkg::job_wr_st_t jq_st
);
  import qpd_pkg::*;

  logic       newline_crlf_r;
  logic       line_started_r, line_started_nxt;
  esc_t       esc_r, esc_nxt;
  logic [4:0] first_digit_r, first_digit_nxt;
  logic       last_eq_r, last_eq_nxt;
  logic       accept;
  logic       is_lf, is_cr, is_eq;
  logic [4:0] d_cur;
  logic       close_line;
  job_t       job;
  logic       job_emit;

  assign cfg_ready = 1'b1;
  assign in_full   = jq_st.full;
  assign accept    = in_push && !jq_st.full;

  assign is_lf = (in_byte == CH_LF);
  assign is_cr = (in_byte == CH_CR);
  assign is_eq = (in_byte == CH_EQ);
  assign d_cur = hex_value(in_byte);

  assign close_line = in_end_of_stream ? line_started_r
                    : ((is_lf || is_cr) && !(!line_started_r && is_lf));

  // next state
  always_comb begin
    line_started_nxt = line_started_r;
    esc_nxt          = esc_r;
    first_digit_nxt  = first_digit_r;
    last_eq_nxt      = last_eq_r;
    if (close_line) begin
      line_started_nxt = 1'b0;
      esc_nxt          = ESC_NONE;
      first_digit_nxt  = '0;
      last_eq_nxt      = 1'b0;
    end else if (!in_end_of_stream) begin
      line_started_nxt = 1'b1;
      if (!(is_lf && !line_started_r)) begin
        last_eq_nxt = is_eq;
        unique case (esc_r)
          ESC_NONE:  if (is_eq) esc_nxt = ESC_EQ;
          ESC_EQ: begin
            first_digit_nxt = d_cur;
            esc_nxt         = ESC_DIGIT;
          end
          ESC_DIGIT: begin
            esc_nxt         = ESC_NONE;
            first_digit_nxt = '0;
          end
          default:   esc_nxt = ESC_NONE;
        endcase
      end
    end
  end

  // job generation
  always_comb begin
    job_emit  = 1'b0;
    job.kind  = JOB_BYTE;
    job.crlf  = newline_crlf_r;
    job.data  = in_byte;
    job.bad   = 1'b0;
    if (close_line) begin
      job_emit = !last_eq_r;
      job.kind = JOB_NL;
    end else if (!in_end_of_stream && !(is_lf && !line_started_r)) begin
      unique case (esc_r)
        ESC_NONE:  job_emit = !is_eq;
        ESC_EQ:    job_emit = 1'b0;
        ESC_DIGIT: begin
          job_emit = 1'b1;
          job.bad  = first_digit_r[4] || d_cur[4];
          if (d_cur[4])              job.data = 8'hFF;
          else if (first_digit_r[4]) job.data = {4'hF, d_cur[3:0]};
          else                       job.data = {first_digit_r[3:0], d_cur[3:0]};
        end
        default:   job_emit = 1'b0;
      endcase
    end
  end

  assign jq_wr.push = accept && job_emit;
  assign jq_wr.job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newline_crlf_r <= 1'b0;
      line_started_r <= 1'b0;
      esc_r          <= ESC_NONE;
      first_digit_r  <= '0;
      last_eq_r      <= 1'b0;
    end else begin
      if (cfg_valid) newline_crlf_r <= cfg_newline_crlf;
      if (accept) begin
        line_started_r <= line_started_nxt;
        esc_r          <= esc_nxt;
        first_digit_r  <= first_digit_nxt;
        last_eq_r      <= last_eq_nxt;
      end
    end
  end

endmodule

/* sv/qpd_fifo.sv */
module qpd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qpd_pkg::job_wr_t     wr,
  output qpd_pkg::job_wr_st_t  wr_st,
  output qpd_pkg::job_rd_t     rd,
  input  logic                 rd_pop
);
  import qpd_pkg::*;

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_st.full = (cnt_r == JQ_CW'(JQ_DEPTH));
  assign rd.valid   = (cnt_r != '0);
  assign rd.job     = mem_r[rd_ptr_r];

  assign do_wr = wr.push && !wr_st.full;
  assign do_rd = rd_pop && rd.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/qpd_back.sv */
module qpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  qpd_pkg::job_rd_t jq_rd,
  output logic             jq_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_bad_hex,
  output logic             out_last_of_run
);
  import qpd_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_bad_r, out_bad_nxt;
  logic       out_last_r, out_last_nxt;
  logic       cr_done_r, cr_done_nxt;
  logic       load, issue;

  assign load  = !out_valid_r || out_pop;
  assign issue = load && jq_rd.valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    cr_done_nxt   = cr_done_r;
    jq_pop        = 1'b0;
    if (load) out_valid_nxt = 1'b0;
    if (issue) begin
      out_valid_nxt = 1'b1;
      out_bad_nxt   = 1'b0;
      out_last_nxt  = 1'b1;
      if (jq_rd.job.kind == JOB_NL) begin
        // CRLF newline spends two beats; the job stays queued for the first
        if (jq_rd.job.crlf && !cr_done_r) begin
          out_byte_nxt = CH_CR;
          out_last_nxt = 1'b0;
          cr_done_nxt  = 1'b1;
        end else begin
          out_byte_nxt = CH_LF;
          cr_done_nxt  = 1'b0;
          jq_pop       = 1'b1;
        end
      end else begin
        out_byte_nxt = jq_rd.job.data;
        out_bad_nxt  = jq_rd.job.bad;
        jq_pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cr_done_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cr_done_r   <= cr_done_nxt;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_bad_hex     = out_bad_r;
  assign out_last_of_run = out_last_r;

endmodule

/* sv/qpd_checker.sv */
module qpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic [7:0] in_byte,
  input logic       in_end_of_stream,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_bad_hex,
  input logic       out_last_of_run,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       cfg_newline_crlf
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte))
    else $error("output beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // a bad escape always decodes to 0xF? and ends its run
  a_bad_hi: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_bad_hex |-> out_byte[7:4] == 4'hF && out_last_of_run)
    else $error("bad_hex on unexpected byte");

  // only the CR of a CRLF pair is a non-final beat
  a_mid_cr: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_last_of_run |-> out_byte == 8'h0D && !out_bad_hex)
    else $error("non-final beat is not CR");

  a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_last_of_run |=>
      !out_empty && out_byte == 8'h0A && out_last_of_run)
    else $error("CR not followed by LF");

endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (.*);

/* tb/sv/quoted_printable_decoder_top_tb.sv */
`timescale 1ns / 100ps

module quoted_printable_decoder_top_tb;
  import qpd_pkg::*;

  localparam int END_MARK    = 256;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 280;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 6;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } dec_beat_t;

  class qp_decode_scoreboard;
    dec_beat_t decoded_q[$];
    int        mismatches;
    bit        crlf;
    bit        line_open;
    esc_t      esc;
    logic [4:0] dig1;
    bit        prev_eq;

    function new();
      mismatches = 0;
      crlf       = 1'b0;
      line_open  = 1'b0;
      esc        = ESC_NONE;
      dig1       = '0;
      prev_eq    = 1'b0;
    endfunction

    // 0..15, or 16 for anything that is not a hex digit
    function logic [4:0] digit_of(logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c >= "a" && c <= "z") u = c - 8'h20;
      if (u >= "0" && u <= "9") return 5'(u - "0");
      if (u >= "A" && u <= "F") return 5'(u - "A" + 10);
      return 5'd16;
    endfunction

    function void add_beat(logic [7:0] data, logic bad);
      dec_beat_t b;
      b.data = data;
      b.bad  = bad;
      b.last = 1'b0;
      decoded_q.push_back(b);
    endfunction

    function void end_line();
      if (!prev_eq) begin
        if (crlf) add_beat(CH_CR, 1'b0);
        add_beat(CH_LF, 1'b0);
      end
      line_open = 1'b0;
      esc       = ESC_NONE;
      dig1      = '0;
      prev_eq   = 1'b0;
    endfunction

    function void absorb_encoded(logic [7:0] b, logic eos);
      int         n0;
      logic [4:0] d2;
      logic [7:0] val;
      n0 = decoded_q.size();
      if (eos) begin
        if (line_open) end_line();
      end else if (!line_open && b == CH_LF) begin
        line_open = 1'b1;
      end else if (b == CH_LF || b == CH_CR) begin
        end_line();
      end else begin
        line_open = 1'b1;
        prev_eq   = (b == CH_EQ);
        case (esc)
          ESC_NONE: begin
            if (b == CH_EQ) esc = ESC_EQ;
            else add_beat(b, 1'b0);
          end
          ESC_EQ: begin
            dig1 = digit_of(b);
            esc  = ESC_DIGIT;
          end
          default: begin
            d2 = digit_of(b);
            if (d2[4]) val = 8'hFF;
            else if (dig1[4]) val = {4'hF, d2[3:0]};
            else val = {dig1[3:0], d2[3:0]};
            add_beat(val, dig1[4] | d2[4]);
            esc  = ESC_NONE;
            dig1 = '0;
          end
        endcase
      end
      if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_decoded(logic [7:0] data, logic bad, logic last);
      dec_beat_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("decoded beat %02h with nothing pending", data));
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %02h, want %02h", data, want.data));
      if (bad !== want.bad)
        report($sformatf("out_bad_hex %b, want %b (byte %02h)", bad, want.bad, want.data));
      if (last !== want.last)
        report($sformatf("out_last_of_run %b, want %b (byte %02h)", last, want.last,
                         want.data));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end_of_stream;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_bad_hex;
  logic       out_last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_newline_crlf;

  qp_decode_scoreboard sb;
  bit fast_tx;
  bit fast_rx;
  bit hold_req;
  int sent;

  quoted_printable_decoder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_bad_hex      (out_bad_hex),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_newline_crlf (cfg_newline_crlf)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_pop === 1'b1 && out_empty === 1'b0)
      sb.check_decoded(out_byte, out_bad_hex, out_last_of_run);
  end

  // result side: random stalls per beat, plus one long hold-off on request
  initial begin
    int gap;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = fast_rx ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      if ($urandom_range(0, 63) == 0) fast_rx = !fast_rx;
    end
  end

  task send_item(logic [7:0] b, logic eos);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_byte          <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.absorb_encoded(b, eos);
    sent++;
    if ($urandom_range(0, 63) == 0) fast_tx = !fast_tx;
  endtask

  task send_code(int code);
    if (code == END_MARK) send_item(8'($urandom_range(0, 255)), 1'b1);
    else send_item(8'(code), 1'b0);
  endtask

  function logic [7:0] pick_digit();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 8'("0" + $urandom_range(0, 9));
    if (k < 65) return 8'("A" + $urandom_range(0, 5));
    if (k < 90) return 8'("a" + $urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [7:0] pick_eol();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // mostly well-formed lines and escapes, some cut escapes and noise
  task send_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 70) begin
      send_item(CH_EQ, 1'b0);
      send_item(pick_digit(), 1'b0);
      send_item(pick_digit(), 1'b0);
    end else if (r < 82) begin
      if ($urandom_range(0, 1)) begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end else begin
        send_item(pick_eol(), 1'b0);
      end
    end else if (r < 88) begin
      send_item(CH_EQ, 1'b0);
      send_item(pick_eol(), 1'b0);
      if ($urandom_range(0, 1)) send_item(CH_LF, 1'b0);
    end else if (r < 92) begin
      send_item(CH_EQ, 1'b0);
      if ($urandom_range(0, 1)) send_item(pick_digit(), 1'b0);
      send_item(pick_eol(), 1'b0);
    end else if (r < 95) begin
      send_code(END_MARK);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // sender pauses until every pending beat is out, then lets the pipe settle
  task drain();
    int cnt;
    in_push <= 1'b0;
    cnt = 0;
    while (sb.decoded_q.size() != 0 && cnt < 20000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_newline_mode(logic crlf);
    cfg_valid        <= 1'b1;
    cfg_newline_crlf <= crlf;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.crlf = crlf;
  endtask

  int dir_seq[] = '{
    8'h00, 8'hFF,
    CH_EQ, "a", "0",
    CH_EQ, "F", "f",
    CH_EQ, "0", "9",
    CH_EQ, "g", "1",
    CH_EQ, "3", "~",
    CH_EQ, CH_CR,
    CH_LF,
    CH_EQ, "4", CH_LF,
    CH_CR,
    END_MARK,
    CH_LF, END_MARK
  };

  bit crlf_plan[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  initial begin
    in_push          <= 1'b0;
    in_byte          <= '0;
    in_end_of_stream <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_newline_crlf <= 1'b0;
    rst_n            <= 1'b0;
    fast_tx  = 1'b0;
    fast_rx  = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_seq[i]) send_code(dir_seq[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_newline_mode(crlf_plan[p]);
      fast_tx = ($urandom_range(0, 3) == 0);
      fast_rx = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // back up the output while the input keeps offering beats
        fast_tx  = 1'b1;
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) send_burst();
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.decoded_q.size() != 0)
      sb.report($sformatf("%0d decoded beats never arrived", sb.decoded_q.size()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
